// ===== sv/assert_macros.svh =====
// Assertion macros shared by the chunk packetizer RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define RCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RCP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/rcp_pkg.sv =====
// Package for the chunk packetizer: payload structs, queue command type, constants.
// No dependencies.
package rcp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd128;
  localparam logic [16:0] CH_MIN         = 17'd2;
  localparam logic [16:0] CH_MAX         = 17'd65599;
  localparam logic [16:0] CH_ONE_LIMIT   = 17'd64;
  localparam logic [16:0] CH_TWO_LIMIT   = 17'd320;
  localparam logic [16:0] CH_OFFSET      = 17'd64;
  localparam logic [7:0]  FMT0_BITS      = 8'h00;
  localparam logic [7:0]  FMT3_BITS      = 8'hc0;
  localparam logic [7:0]  FMT_MASK       = 8'hc0;
  localparam logic [7:0]  THREE_BYTE_TAG = 8'h01;
  localparam logic [7:0]  CH_LOW_MASK    = 8'h3f;
  localparam logic [3:0]  HDR0_BYTES     = 4'd11;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [23:0] message_length;
    logic [16:0] channel_id;
    logic [23:0] time_stamp;
    logic [7:0]  message_type;
    logic [31:0] stream_number;
  } rcp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_end;
    logic       last;
  } rcp_out_t;

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_TYPE0,
    HDR_TYPE3
  } rcp_hdr_e;

  // One accepted payload byte with everything needed to put it on the wire.
  typedef struct packed {
    rcp_hdr_e        hdr;
    logic [1:0]      basic_len;
    logic [2:0][7:0] basic;
    logic [23:0]     time_stamp;
    logic [23:0]     message_length;
    logic [7:0]      message_type;
    logic [31:0]     stream_number;
    logic [7:0]      payload_byte;
    logic            chunk_end;
  } rcp_cmd_t;

  // Queue write side.
  typedef struct packed {
    logic     push;
    rcp_cmd_t cmd;
  } rcp_push_t;

  // Queue read side as seen by the serializer.
  typedef struct packed {
    logic     valid;
    rcp_cmd_t cmd;
  } rcp_head_t;

endpackage

// ===== sv/rcp_queue.sv =====
// Small command queue between front and back of the chunk packetizer.
// Depends on rcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcp_queue import rcp_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rcp_push_t wr_i,
  output logic      full_o,
  output rcp_head_t head_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rcp_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.cmd;
    end
  end

  `RCP_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(Depth), "queue count above depth")
  `RCP_ASSERT(a_no_push_full, full_o |-> !do_push, "queue written while full")

endmodule

// ===== sv/rcp_front.sv =====
// Front end of the chunk packetizer: tracks message and chunk position, builds
// one command per payload byte. Depends on rcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcp_front import rcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rcp_in_t     in_data_i,
  input  logic [15:0] max_payload_i,
  input  logic        queue_full_i,
  output rcp_push_t   wr_o
);

  logic [23:0] msg_left_q, msg_left_d;
  logic [15:0] chunk_pos_q, chunk_pos_d;
  logic [16:0] held_ch_q, held_ch_d;

  logic        accept, first, drop;
  logic [16:0] ch_clamp, ch_cur, ch_off;
  logic [23:0] left_cur, left_nxt;
  logic [15:0] pos_cur, pos_nxt, size_eff;
  logic        end_chunk;
  logic [7:0]  fmt;
  logic        held_ok, msg_done, pos_idle;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign first      = (msg_left_q == '0);
  assign drop       = first && (in_data_i.message_length == '0);

  always_comb begin
    if (in_data_i.channel_id < CH_MIN) begin
      ch_clamp = CH_MIN;
    end else if (in_data_i.channel_id > CH_MAX) begin
      ch_clamp = CH_MAX;
    end else begin
      ch_clamp = in_data_i.channel_id;
    end
  end

  assign ch_cur    = first ? ch_clamp : held_ch_q;
  assign left_cur  = first ? in_data_i.message_length : msg_left_q;
  assign pos_cur   = first ? '0 : chunk_pos_q;
  assign pos_nxt   = pos_cur + 16'd1;
  assign left_nxt  = left_cur - 24'd1;
  assign size_eff  = (max_payload_i == '0) ? 16'd1 : max_payload_i;
  assign end_chunk = (pos_nxt >= size_eff) || (left_nxt == '0);
  assign ch_off    = ch_cur - CH_OFFSET;
  assign fmt       = first ? FMT0_BITS : FMT3_BITS;

  // Command build
  always_comb begin
    wr_o.push               = accept && !drop;
    wr_o.cmd.hdr            = first ? HDR_TYPE0 : ((chunk_pos_q == '0) ? HDR_TYPE3 : HDR_NONE);
    wr_o.cmd.time_stamp     = in_data_i.time_stamp;
    wr_o.cmd.message_length = in_data_i.message_length;
    wr_o.cmd.message_type   = in_data_i.message_type;
    wr_o.cmd.stream_number  = in_data_i.stream_number;
    wr_o.cmd.payload_byte   = in_data_i.payload_byte;
    wr_o.cmd.chunk_end      = end_chunk;
    wr_o.cmd.basic          = '0;
    if (ch_cur < CH_ONE_LIMIT) begin
      wr_o.cmd.basic_len = 2'd1;
      wr_o.cmd.basic[0]  = fmt | (ch_cur[7:0] & CH_LOW_MASK);
    end else if (ch_cur < CH_TWO_LIMIT) begin
      wr_o.cmd.basic_len = 2'd2;
      wr_o.cmd.basic[0]  = fmt & FMT_MASK;
      wr_o.cmd.basic[1]  = ch_off[7:0];
    end else begin
      wr_o.cmd.basic_len = 2'd3;
      wr_o.cmd.basic[0]  = (fmt & FMT_MASK) | THREE_BYTE_TAG;
      wr_o.cmd.basic[1]  = ch_off[7:0];
      wr_o.cmd.basic[2]  = ch_off[15:8];
    end
    if (wr_o.cmd.hdr == HDR_NONE) begin
      wr_o.cmd.basic_len = 2'd0;
    end
  end

  always_comb begin
    msg_left_d  = msg_left_q;
    chunk_pos_d = chunk_pos_q;
    held_ch_d   = held_ch_q;
    if (accept && !drop) begin
      msg_left_d  = left_nxt;
      chunk_pos_d = end_chunk ? '0 : pos_nxt;
      held_ch_d   = ch_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_left_q  <= '0;
      chunk_pos_q <= '0;
      held_ch_q   <= '0;
    end else begin
      msg_left_q  <= msg_left_d;
      chunk_pos_q <= chunk_pos_d;
      held_ch_q   <= held_ch_d;
    end
  end

  assign held_ok  = (held_ch_q >= CH_MIN) && (held_ch_q <= CH_MAX);
  assign msg_done = wr_o.push && (left_nxt == '0);
  assign pos_idle = (msg_left_q == '0) && (chunk_pos_q == '0);

  `RCP_ASSERT(a_held_ch_range, (msg_left_q != '0) |-> held_ok, "held channel out of range")
  `RCP_ASSERT(a_msg_end_pos, msg_done |=> pos_idle, "message end did not clear position")

endmodule

// ===== sv/rcp_back.sv =====
// Back end of the chunk packetizer: serializes one command into header and
// payload bytes through a registered output. Depends on rcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcp_back import rcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rcp_head_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rcp_out_t  out_data_o
);

  logic [3:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  rcp_out_t   out_data_q, out_data_d;

  logic       emit, in_basic, in_hdr0, is_last;
  logic [3:0] nb, hidx, pay_idx;
  logic [7:0] hdr_byte, byte_sel;

  assign nb       = {2'b00, head_i.cmd.basic_len};
  assign hidx     = idx_q - nb;
  assign in_basic = (idx_q < nb);
  assign in_hdr0  = (head_i.cmd.hdr == HDR_TYPE0) && (hidx < HDR0_BYTES);
  assign pay_idx  = nb + ((head_i.cmd.hdr == HDR_TYPE0) ? HDR0_BYTES : 4'd0);
  assign is_last  = (idx_q == pay_idx);

  // Output register free or draining this cycle.
  assign emit  = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = emit && is_last;

  always_comb begin
    case (hidx)
      4'd0:    hdr_byte = head_i.cmd.time_stamp[23:16];
      4'd1:    hdr_byte = head_i.cmd.time_stamp[15:8];
      4'd2:    hdr_byte = head_i.cmd.time_stamp[7:0];
      4'd3:    hdr_byte = head_i.cmd.message_length[23:16];
      4'd4:    hdr_byte = head_i.cmd.message_length[15:8];
      4'd5:    hdr_byte = head_i.cmd.message_length[7:0];
      4'd6:    hdr_byte = head_i.cmd.message_type;
      4'd7:    hdr_byte = head_i.cmd.stream_number[31:24];
      4'd8:    hdr_byte = head_i.cmd.stream_number[23:16];
      4'd9:    hdr_byte = head_i.cmd.stream_number[15:8];
      4'd10:   hdr_byte = head_i.cmd.stream_number[7:0];
      default: hdr_byte = head_i.cmd.payload_byte;
    endcase
  end

  always_comb begin
    if (in_basic) begin
      byte_sel = head_i.cmd.basic[idx_q[1:0]];
    end else if (in_hdr0) begin
      byte_sel = hdr_byte;
    end else begin
      byte_sel = head_i.cmd.payload_byte;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (emit) begin
      idx_d                = is_last ? '0 : idx_q + 4'd1;
      out_valid_d          = 1'b1;
      out_data_d.out_byte  = byte_sel;
      out_data_d.chunk_end = is_last && head_i.cmd.chunk_end;
      out_data_d.last      = is_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `RCP_ASSERT(a_pop_marks_last, pop_o |=> (out_valid_q && out_data_q.last), "pop without last byte")
  `RCP_ASSERT(a_idx_has_head, (idx_q != '0) |-> head_i.valid, "mid-command with empty queue")

endmodule

// ===== sv/rtmp_chunk_packetizer.sv =====
// Accepted requests go into the queue, then out through the output register.
// Throughput: one input request per cycle for plain payload bytes unless the queue is full
//   or the output stalls; a message's first byte emits 13..15 bytes and a chunk's first byte
//   2..4 bytes, one per cycle, set by the single byte serializer on the output register.
// Reset (rst_ni low, async): no message open, queue empty, output invalid,
//   chunk size 128.
`include "assert_macros.svh"

module rtmp_chunk_packetizer import rcp_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: chunk size register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Payload byte requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rcp_in_t     in_data_i,
  // Wire byte stream
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rcp_out_t    out_data_o
);

  // Chunk size register; zero acts as one, handled in the front end.
  logic [15:0] max_payload_q, max_payload_d;

  rcp_push_t   wr;
  rcp_head_t   head;
  logic        queue_full;
  logic        pop;

  assign max_payload_d = cfg_we_i ? cfg_wdata_i : max_payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else begin
      max_payload_q <= max_payload_d;
    end
  end

  // Front: message/chunk tracking, one command per payload byte. Zero-length
  // first bytes are swallowed here and never reach the queue.
  rcp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .max_payload_i (max_payload_q),
    .queue_full_i  (queue_full),
    .wr_o          (wr)
  );

  // Decouples header bursts on the output from the input side.
  rcp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Back: walks basic header, type-0 header and payload byte of each command.
  rcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Every request that enters the queue must eventually leave through the back
  // end; a pop can only happen on a byte that went out.
  `RCP_ASSERT(a_pop_needs_head, pop |-> head.valid, "pop from empty queue")
  `RCP_ASSERT(a_stall_when_full, queue_full |-> in_stall_o, "input taken while queue full")

endmodule
